// ===== design/shef_pkg.sv =====
// ----------------------------------------------------------------------------
// shef_pkg
// Shared types and constants of the Sobel horizontal edge filter.
// ----------------------------------------------------------------------------
package shef_pkg;

   localparam int DEFAULT_MAX_WIDTH  = 512;
   localparam int DEFAULT_MAX_HEIGHT = 512;
   localparam int DIM_RESET          = 512;
   localparam int CSR_DATA_WIDTH     = 10;
   localparam int PIXEL_WIDTH        = 8;
   localparam int PIXEL_MAX          = 255;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_DRAIN = 1'b1
   } op_type;

   localparam logic REG_FRAME_WIDTH  = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;

   typedef struct packed {
      logic live;
      logic emit;
      logic interior;
      logic last;
   } item_type;

   typedef struct packed {
      logic                   en;
      logic [PIXEL_WIDTH-1:0] older_data;
      logic [PIXEL_WIDTH-1:0] newer_data;
   } wr_type;

endpackage

// ===== design/shef_ctrl.sv =====
// ----------------------------------------------------------------------------
// shef_ctrl
// Frame size registers, input and output position counters and the per-item
// decision taken when an item is accepted.
// ----------------------------------------------------------------------------
module shef_ctrl #(
   parameter int MAX_WIDTH  = shef_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = shef_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_write_enable,
   input  logic                                    csr_index,
   input  logic [shef_pkg::CSR_DATA_WIDTH-1:0]     csr_write_data,
   input  logic                                    accept,
   input  logic                                    op,
   output shef_pkg::item_type                      item,
   output logic [$clog2(MAX_WIDTH)-1:0]            column
);
   import shef_pkg::*;

   localparam int DW = $clog2(MAX_WIDTH + 1);
   localparam int RW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RESET_W = (DIM_RESET > MAX_WIDTH) ? MAX_WIDTH : DIM_RESET;
   localparam int RESET_H = (DIM_RESET > MAX_HEIGHT) ? MAX_HEIGHT : DIM_RESET;

   logic [DW-1:0] width_ff, width_in;
   logic [RW-1:0] height_ff, height_in;
   logic [DW-1:0] in_col_ff, in_col_in;
   logic [RW-1:0] in_row_ff, in_row_in;
   logic [DW-1:0] out_col_ff, out_col_in;
   logic [RW-1:0] out_row_ff, out_row_in;
   logic          frame_done;
   logic [31:0]   data_ext;
   logic [31:0]   width_clamp;
   logic [31:0]   height_clamp;

   assign data_ext = {{(32 - CSR_DATA_WIDTH){1'b0}}, csr_write_data};

   always_comb begin
      if (data_ext == 32'd0) begin
         width_clamp  = 32'd1;
         height_clamp = 32'd1;
      end else begin
         width_clamp  = (data_ext > 32'(MAX_WIDTH)) ? 32'(MAX_WIDTH) : data_ext;
         height_clamp = (data_ext > 32'(MAX_HEIGHT)) ? 32'(MAX_HEIGHT) : data_ext;
      end
   end

   assign frame_done = (in_row_ff >= height_ff);
   assign column     = in_col_ff[CW-1:0];

   always_comb begin
      item = '0;
      if (op == OP_DRAIN) begin
         item.emit = frame_done;
         item.last = frame_done && (out_row_ff == height_ff - RW'(1))
                     && (out_col_ff == width_ff - DW'(1));
      end else begin
         item.live     = !frame_done;
         item.emit     = !frame_done && ((in_row_ff >= RW'(2))
                         || ((in_row_ff == RW'(1)) && (in_col_ff != '0)));
         item.interior = item.emit && (out_row_ff != '0)
                         && (out_row_ff + RW'(1) != height_ff)
                         && (out_col_ff != '0)
                         && (out_col_ff + DW'(1) != width_ff);
      end
   end

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            REG_FRAME_WIDTH:  width_in  = DW'(width_clamp);
            REG_FRAME_HEIGHT: height_in = RW'(height_clamp);
         endcase
         in_col_in  = '0;
         in_row_in  = '0;
         out_col_in = '0;
         out_row_in = '0;
      end else if (accept) begin
         if (item.live) begin
            if (in_col_ff + DW'(1) == width_ff) begin
               in_col_in = '0;
               in_row_in = in_row_ff + RW'(1);
            end else begin
               in_col_in = in_col_ff + DW'(1);
            end
         end
         if (item.emit) begin
            if (out_col_ff + DW'(1) == width_ff) begin
               out_col_in = '0;
               out_row_in = out_row_ff + RW'(1);
            end else begin
               out_col_in = out_col_ff + DW'(1);
            end
         end
         if (item.last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= DW'(RESET_W);
         height_ff  <= RW'(RESET_H);
         in_col_ff  <= '0;
         in_row_ff  <= '0;
         out_col_ff <= '0;
         out_row_ff <= '0;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

endmodule

// ===== design/shef_line_buf.sv =====
// ----------------------------------------------------------------------------
// shef_line_buf
// Two row memories holding the two rows above the input row, with a
// registered read and forwarding of a write to the same column.
// ----------------------------------------------------------------------------
module shef_line_buf #(
   parameter int MAX_WIDTH = shef_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]         rd_addr,
   input  shef_pkg::wr_type                     wr,
   input  logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
   output logic [shef_pkg::PIXEL_WIDTH-1:0]     top,
   output logic [shef_pkg::PIXEL_WIDTH-1:0]     mid
);
   import shef_pkg::*;

   logic [PIXEL_WIDTH-1:0] older_mem [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0] newer_mem [MAX_WIDTH];
   logic [PIXEL_WIDTH-1:0] top_ff;
   logic [PIXEL_WIDTH-1:0] mid_ff;
   logic                   forward;

   assign forward = wr.en && (wr_addr == rd_addr);
   assign top     = top_ff;
   assign mid     = mid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         older_mem[wr_addr] <= wr.older_data;
         newer_mem[wr_addr] <= wr.newer_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         top_ff <= forward ? wr.older_data : older_mem[rd_addr];
         mid_ff <= forward ? wr.newer_data : newer_mem[rd_addr];
      end
   end

endmodule

// ===== design/shef_kernel.sv =====
// ----------------------------------------------------------------------------
// shef_kernel
// Item register, 3x3 window columns, gradient arithmetic with clamping and
// the result register.
// ----------------------------------------------------------------------------
module shef_kernel #(
   parameter int MAX_WIDTH = shef_pkg::DEFAULT_MAX_WIDTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 accept,
   input  shef_pkg::item_type                   item,
   input  logic [$clog2(MAX_WIDTH)-1:0]         column,
   input  logic [shef_pkg::PIXEL_WIDTH-1:0]     pixel,
   input  logic [shef_pkg::PIXEL_WIDTH-1:0]     top,
   input  logic [shef_pkg::PIXEL_WIDTH-1:0]     mid,
   input  logic                                 rsp_ready,
   output logic                                 req_ready,
   output shef_pkg::wr_type                     wr,
   output logic [$clog2(MAX_WIDTH)-1:0]         wr_addr,
   output logic                                 rsp_valid,
   output logic [shef_pkg::PIXEL_WIDTH-1:0]     rsp_edge_value,
   output logic                                 rsp_frame_last
);
   import shef_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic                   s1_valid_ff, s1_valid_in;
   item_type               s1_item_ff;
   logic [CW-1:0]          s1_column_ff;
   logic [PIXEL_WIDTH-1:0] s1_pixel_ff;
   logic [PIXEL_WIDTH-1:0] win0_ff, win3_ff, win2_ff, win5_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_WIDTH-1:0] edge_ff;
   logic                   last_ff;
   logic                   s1_go;
   logic                   s1_fire;
   logic [PIXEL_WIDTH+1:0] lower;
   logic [PIXEL_WIDTH+1:0] upper;
   logic signed [PIXEL_WIDTH+2:0] diff;
   logic [PIXEL_WIDTH-1:0] edge_in;

   assign s1_go     = !s1_item_ff.emit || !rsp_valid_ff || rsp_ready;
   assign s1_fire   = s1_valid_ff && s1_go;
   assign req_ready = !s1_valid_ff || s1_go;

   assign wr.en         = s1_fire && s1_item_ff.live;
   assign wr.older_data = mid;
   assign wr.newer_data = s1_pixel_ff;
   assign wr_addr       = s1_column_ff;

   assign lower = {2'b00, win2_ff} + {1'b0, win5_ff, 1'b0} + {2'b00, s1_pixel_ff};
   assign upper = {2'b00, win0_ff} + {1'b0, win3_ff, 1'b0} + {2'b00, top};
   assign diff  = $signed({1'b0, lower}) - $signed({1'b0, upper});

   always_comb begin
      if (!s1_item_ff.interior || diff < 0) begin
         edge_in = '0;
      end else if (diff > $signed((PIXEL_WIDTH + 3)'(PIXEL_MAX))) begin
         edge_in = PIXEL_WIDTH'(PIXEL_MAX);
      end else begin
         edge_in = diff[PIXEL_WIDTH-1:0];
      end
   end

   always_comb begin
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      if (s1_fire && s1_item_ff.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s1_item_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         win0_ff      <= '0;
         win3_ff      <= '0;
         win2_ff      <= '0;
         win5_ff      <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            s1_item_ff <= item;
         end
         if (wr.en) begin
            win0_ff <= win3_ff;
            win3_ff <= top;
            win2_ff <= win5_ff;
            win5_ff <= s1_pixel_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_column_ff <= column;
         s1_pixel_ff  <= pixel;
      end
      if (s1_fire && s1_item_ff.emit) begin
         edge_ff <= edge_in;
         last_ff <= s1_item_ff.last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_edge_value = edge_ff;
   assign rsp_frame_last = last_ff;

endmodule

// ===== design/sobel_horizontal_edge_filter.sv =====
// ----------------------------------------------------------------------------
// sobel_horizontal_edge_filter
// Streaming 3x3 Sobel vertical-gradient filter with two row memories,
// clamped output, zero border and a flag on the last result of a frame.
// ----------------------------------------------------------------------------
//   Channel  Direction  Signals
//   req      in         req_valid, req_ready, req_op, req_pixel
//   rsp      out        rsp_valid, rsp_ready, rsp_edge_value, rsp_frame_last
//   csr      in         csr_write_enable, csr_index, csr_write_data
//
// One item is taken every cycle while the item register is not stalled; a result
// is registered once the item that causes it leaves the item register.
// The rate is set by the single item register feeding the result register,
// with the row memories read at acceptance and written as the item leaves it.
// Reset is synchronous; the frame size returns to 512 by 512 or the maximum if less.
// A waiting result stalls the item register only when it also holds a result.
// ----------------------------------------------------------------------------
module sobel_horizontal_edge_filter #(
   parameter int MAX_WIDTH  = shef_pkg::DEFAULT_MAX_WIDTH,
   parameter int MAX_HEIGHT = shef_pkg::DEFAULT_MAX_HEIGHT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_op,
   input  logic [shef_pkg::PIXEL_WIDTH-1:0]     req_pixel,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [shef_pkg::PIXEL_WIDTH-1:0]     rsp_edge_value,
   output logic                                 rsp_frame_last,
   input  logic                                 csr_write_enable,
   input  logic                                 csr_index,
   input  logic [shef_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);
   import shef_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);

   logic                   accept;
   item_type               item;
   logic [CW-1:0]          column;
   wr_type                 wr;
   logic [CW-1:0]          wr_addr;
   logic [PIXEL_WIDTH-1:0] top;
   logic [PIXEL_WIDTH-1:0] mid;

   assign accept = req_valid && req_ready;

   shef_ctrl #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .accept           (accept),
      .op               (req_op),
      .item             (item),
      .column           (column)
   );

   shef_line_buf #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_line_buf (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (column),
      .wr      (wr),
      .wr_addr (wr_addr),
      .top     (top),
      .mid     (mid)
   );

   shef_kernel #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_kernel (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .item           (item),
      .column         (column),
      .pixel          (req_pixel),
      .top            (top),
      .mid            (mid),
      .rsp_ready      (rsp_ready),
      .req_ready      (req_ready),
      .wr             (wr),
      .wr_addr        (wr_addr),
      .rsp_valid      (rsp_valid),
      .rsp_edge_value (rsp_edge_value),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule
